// ===== rtl/name_to_id_lookup_table_defines.svh =====
// Assertion macros for the name-to-id lookup table checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef NAME_TO_ID_LOOKUP_TABLE_DEFINES_SVH
`define NAME_TO_ID_LOOKUP_TABLE_DEFINES_SVH

// Same-cycle implication, off while reset is held
`define NLT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nlt check failed");

// Next-cycle implication, off while reset is held
`define NLT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nlt check failed");

`endif

// ===== rtl/nlt_pkg.sv =====
// Shared types and codes for the name-to-id lookup table.
// No dependencies; used by nlt_cell, the top level and nlt_checker.
package nlt_pkg;

  localparam int unsigned FoundBits = 8;

  typedef enum logic [0:0] {
    OP_REGISTER = 1'b0,
    OP_LOOKUP   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // Control part of a request word moving down the chain
  typedef struct packed {
    logic    valid;
    op_e     op;
    logic    done;
    status_e status;
  } ctl_t;

endpackage

// ===== rtl/nlt_cell.sv =====
// One table entry of the lookup chain plus its stage register.
// Depends on nlt_pkg for the request control struct and codes.
module nlt_cell #(
  parameter int unsigned KEY_BITS = 64,
  parameter int unsigned ID_BITS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  nlt_pkg::ctl_t                 ctl_i,
  input  logic [KEY_BITS-1:0]           key_i,
  input  logic [ID_BITS-1:0]            id_i,
  input  logic [nlt_pkg::FoundBits-1:0] found_i,
  output nlt_pkg::ctl_t                 ctl_o,
  output logic [KEY_BITS-1:0]           key_o,
  output logic [ID_BITS-1:0]            id_o,
  output logic [nlt_pkg::FoundBits-1:0] found_o
);
  import nlt_pkg::*;

  logic                ent_valid_q, ent_valid_d;
  logic [KEY_BITS-1:0] ent_key_q, ent_key_d;
  logic [ID_BITS-1:0]  ent_owner_q, ent_owner_d;
  ctl_t                ctl_q, ctl_d;
  logic [KEY_BITS-1:0] key_q;
  logic [ID_BITS-1:0]  id_q;
  logic [FoundBits-1:0] found_q, found_d;

  // Entries fill from the bottom and are never freed, so the first empty
  // cell means no match lies further down: claim it or report a miss.
  always_comb begin
    ent_valid_d = ent_valid_q;
    ent_key_d   = ent_key_q;
    ent_owner_d = ent_owner_q;
    ctl_d       = ctl_i;
    found_d     = found_i;
    if (ctl_i.valid && !ctl_i.done) begin
      if (ent_valid_q && (ent_key_q == key_i)) begin
        ctl_d.done   = 1'b1;
        ctl_d.status = ST_OK;
        if (ctl_i.op == OP_REGISTER) begin
          ent_owner_d = id_i;
        end else begin
          found_d = FoundBits'(ent_owner_q);
        end
      end else if (!ent_valid_q) begin
        ctl_d.done = 1'b1;
        if (ctl_i.op == OP_REGISTER) begin
          ent_valid_d  = 1'b1;
          ent_key_d    = key_i;
          ent_owner_d  = id_i;
          ctl_d.status = ST_OK;
        end else begin
          ctl_d.status = ST_NOT_FOUND;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
      ctl_q       <= '0;
    end else if (adv_i) begin
      ent_valid_q <= ent_valid_d;
      ctl_q       <= ctl_d;
    end
  end

  // Entry and word payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ent_key_q   <= ent_key_d;
      ent_owner_q <= ent_owner_d;
      key_q       <= key_i;
      id_q        <= id_i;
      found_q     <= found_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign key_o   = key_q;
  assign id_o    = id_q;
  assign found_o = found_q;

endmodule

// ===== rtl/name_to_id_lookup_table.sv =====
// Top level of the name-to-id lookup table: input stage, chain of entry
// cells and result formatting. Depends on nlt_pkg and nlt_cell.
//
//  channel  dir  tdata                                 tuser
//  s_*      in   [63:0] key_name, [71:64] sender_id    [0] op
//  m_*      out  [7:0] found_id                        [1:0] status
//
// A word passes from acceptance to result through one input stage and one
// stage per entry cell. Words follow each other one per cycle while m_* is not stalled.
// Reset clears all entry valid bits at once; no sweep is needed.
// A result held on m_* stalls the whole chain, and s_tready_o drops with it.
module name_to_id_lookup_table #(
  parameter int unsigned ENTRIES   = 32,
  parameter int unsigned KEY_CHARS = 8,
  parameter int unsigned ID_BITS   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [71:0] s_tdata_i,  // [63:0] key_name, [71:64] sender_id
  input  logic [0:0]  s_tuser_i,  // [0] op
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [7:0]  m_tdata_o,  // [7:0] found_id
  output logic [1:0]  m_tuser_o   // [1:0] status
);
  import nlt_pkg::*;

  localparam int unsigned KeyBits = 8 * KEY_CHARS;

  logic                 adv;
  logic [KeyBits-1:0]   key_norm;
  ctl_t                 in_ctl;
  ctl_t                 ctl_ch   [ENTRIES+1];
  logic [KeyBits-1:0]   key_ch   [ENTRIES+1];
  logic [ID_BITS-1:0]   id_ch    [ENTRIES+1];
  logic [FoundBits-1:0] found_ch [ENTRIES+1];
  ctl_t                 last_ctl;

  // Whole chain moves when the output slot is free or being taken
  assign adv        = !m_tvalid_o || m_tready_i;
  assign s_tready_o = adv;

  // Cut to KEY_CHARS bytes and clear everything after the first zero byte
  always_comb begin
    logic alive;
    alive    = 1'b1;
    key_norm = '0;
    for (int unsigned i = 0; i < KEY_CHARS; i++) begin
      alive = alive && (s_tdata_i[8*i +: 8] != 8'd0);
      if (alive) begin
        key_norm[8*i +: 8] = s_tdata_i[8*i +: 8];
      end
    end
  end

  always_comb begin
    in_ctl        = '0;
    in_ctl.valid  = s_tvalid_i;
    in_ctl.op     = op_e'(s_tuser_i[0]);
    in_ctl.done   = 1'b0;
    in_ctl.status = ST_OK;
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_ch[0] <= '0;
    end else if (adv) begin
      ctl_ch[0] <= in_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      key_ch[0]   <= key_norm;
      id_ch[0]    <= ID_BITS'(s_tdata_i[71:64]);
      found_ch[0] <= '0;
    end
  end

  // Entry cells
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    nlt_cell #(
      .KEY_BITS (KeyBits),
      .ID_BITS  (ID_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .ctl_i   (ctl_ch[g]),
      .key_i   (key_ch[g]),
      .id_i    (id_ch[g]),
      .found_i (found_ch[g]),
      .ctl_o   (ctl_ch[g+1]),
      .key_o   (key_ch[g+1]),
      .id_o    (id_ch[g+1]),
      .found_o (found_ch[g+1])
    );
  end

  // Result: a word that passed every cell unresolved hit a full table
  assign last_ctl   = ctl_ch[ENTRIES];
  assign m_tvalid_o = last_ctl.valid;

  always_comb begin
    if (last_ctl.done) begin
      m_tuser_o = last_ctl.status;
      m_tdata_o = found_ch[ENTRIES];
    end else begin
      m_tuser_o = (last_ctl.op == OP_REGISTER) ? ST_FULL : ST_NOT_FOUND;
      m_tdata_o = '0;
    end
  end

endmodule

// ===== rtl/nlt_checker.sv =====
// Port-level checks for the name-to-id lookup table, bound to the top.
// Depends on nlt_pkg and name_to_id_lookup_table_defines.svh.
`include "name_to_id_lookup_table_defines.svh"

module nlt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tready_o,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [7:0]  m_tdata_o,
  input logic [1:0]  m_tuser_o
);
  import nlt_pkg::*;

  // Only a successful lookup carries an id
  `NLT_ASSERT_IMP(a_id_zero_on_fail, m_tvalid_o && (m_tuser_o != ST_OK), m_tdata_o == 8'd0)

  // Input side stalls only behind a held result
  `NLT_ASSERT_IMP(a_stall_cause, !s_tready_o, m_tvalid_o && !m_tready_i)

  // Chain output is registered and reset: nothing comes out right after reset
  `NLT_ASSERT_IMP(a_no_early_result, !$past(rst_ni), !m_tvalid_o)

  // Held result word stays put
  `NLT_ASSERT_NXT(a_out_hold, m_tvalid_o && !m_tready_i,
    m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))

endmodule

bind name_to_id_lookup_table nlt_checker u_nlt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o)
);
